// File: rtl/bls_pkg.sv
`default_nettype none
package bls_pkg;

  // Canvas registers are fixed at 15 bits, unsigned
  localparam int CANVAS_BITS    = 15;
  localparam int CFG_INDEX_BITS = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CANVAS_HEIGHT = 1'b1;

  // Canvas reset values
  localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RESET  = 15'd640;
  localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RESET = 15'd480;

  // Request kind carried on the input tuser
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } bls_mode_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic can_push;
    logic has_data;
  } bls_q_status_t;

endpackage
`default_nettype wire

// File: rtl/bls_front.sv
`default_nettype none
module bls_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         in_mode,
  input  wire logic signed [COORD_BITS-1:0] x_start,
  input  wire logic signed [COORD_BITS-1:0] y_start,
  input  wire logic signed [COORD_BITS-1:0] x_end,
  input  wire logic signed [COORD_BITS-1:0] y_end,
  // entry, lowest bit up: mode, x0, y0, x1, y1, dx, ndy, step_x_neg, step_y_neg
  output logic [6*COORD_BITS+6-1:0]         entry
);
  import bls_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int NW = CB + 2;

  logic signed [CB:0]   diff_x;
  logic signed [CB:0]   diff_y;
  logic        [DW-1:0] dx_abs;
  logic signed [NW-1:0] ndy;
  logic                 sx_neg;
  logic                 sy_neg;
  bls_mode_t            mode;

  // Classify the request and set up the line deltas and step signs
  always_comb begin
    mode   = bls_mode_t'(in_mode);
    diff_x = (CB+1)'(x_end) - (CB+1)'(x_start);
    diff_y = (CB+1)'(y_end) - (CB+1)'(y_start);
    dx_abs = (diff_x < 0) ? DW'(-diff_x) : DW'(diff_x);
    ndy    = (diff_y < 0) ? NW'(diff_y) : -NW'(diff_y);
    sx_neg = !(diff_x > 0);
    sy_neg = !(diff_y > 0);
  end

  assign entry = {sy_neg, sx_neg, ndy, dx_abs, y_end, x_end, y_start, x_start,
                  (mode == MODE_STEP)};

endmodule
`default_nettype wire

// File: rtl/bls_queue.sv
`default_nettype none
module bls_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic [WIDTH-1:0]      push_data,
  input  wire logic                  pop,
  output logic [WIDTH-1:0]           pop_data,
  output bls_pkg::bls_q_status_t     status
);
  import bls_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign status.can_push = (count_r != FULL_CNT);
  assign status.has_data = (count_r != '0);
  assign do_push         = push && status.can_push;
  assign do_pop          = pop && status.has_data;
  assign pop_data        = slots_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bls_back.sv
`default_nettype none
module bls_back #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [bls_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [bls_pkg::CANVAS_BITS-1:0]     cfg_wdata,
  input  wire bls_pkg::bls_q_status_t              q_status,
  input  wire logic [6*COORD_BITS+6-1:0]           q_entry,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [COORD_BITS-1:0]             pixel_x,
  output logic signed [COORD_BITS-1:0]             pixel_y,
  output logic                                     inside_res,
  output logic                                     last
);
  import bls_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int DW      = CB + 1;
  localparam int NW      = CB + 2;
  localparam int EW      = CB + 3;
  localparam int CMPW    = ((CB > CANVAS_BITS) ? CB : CANVAS_BITS) + 1;
  localparam int OFS_X0  = 1;
  localparam int OFS_Y0  = OFS_X0 + CB;
  localparam int OFS_X1  = OFS_Y0 + CB;
  localparam int OFS_Y1  = OFS_X1 + CB;
  localparam int OFS_DX  = OFS_Y1 + CB;
  localparam int OFS_NDY = OFS_DX + DW;
  localparam int OFS_SX  = OFS_NDY + NW;
  localparam int OFS_SY  = OFS_SX + 1;
  localparam logic signed [CB-1:0] ONE_C = CB'(1);

  // Line state
  logic signed [CB-1:0]     cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic        [DW-1:0]     dx_r;
  logic signed [NW-1:0]     ndy_r;
  logic                     sx_neg_r, sy_neg_r;
  logic signed [EW-1:0]     err_r;
  logic                     active_r;
  logic [CANVAS_BITS-1:0]   canvas_w_r, canvas_h_r;

  // Output register
  logic                     out_valid_r;
  logic signed [CB-1:0]     pix_x_r, pix_y_r;
  logic                     inside_r, last_r;

  // Decoded queue entry
  bls_mode_t                e_mode;
  logic signed [CB-1:0]     e_x0, e_y0, e_x1, e_y1;
  logic        [DW-1:0]     e_dx;
  logic signed [NW-1:0]     e_ndy;
  logic                     e_sx, e_sy;

  // Step datapath
  logic signed [EW:0]       e2, ndy_cmp, dx_cmp;
  logic signed [EW-1:0]     ndy_w, dx_w, e_ndy_w, e_dx_w;
  logic                     move_x, move_y;
  logic signed [EW-1:0]     err_step;
  logic signed [CB-1:0]     x_step, y_step;

  // Next values
  logic                     is_start, do_emit, fire;
  logic signed [CB-1:0]     cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt;
  logic signed [EW-1:0]     err_nxt;
  logic                     at_end;
  logic signed [CMPW-1:0]   px_c, py_c, w_c, h_c;
  logic                     inside_nxt;

  always_comb begin
    e_mode = bls_mode_t'(q_entry[0]);
    e_x0   = q_entry[OFS_X0 +: CB];
    e_y0   = q_entry[OFS_Y0 +: CB];
    e_x1   = q_entry[OFS_X1 +: CB];
    e_y1   = q_entry[OFS_Y1 +: CB];
    e_dx   = q_entry[OFS_DX +: DW];
    e_ndy  = q_entry[OFS_NDY +: NW];
    e_sx   = q_entry[OFS_SX];
    e_sy   = q_entry[OFS_SY];
  end

  // Advance the error term and pick the axes that move
  always_comb begin
    e2       = {err_r, 1'b0};
    ndy_cmp  = (EW+1)'(ndy_r);
    dx_cmp   = $signed((EW+1)'(dx_r));
    ndy_w    = EW'(ndy_r);
    dx_w     = $signed(EW'(dx_r));
    move_x   = (ndy_cmp <= e2);
    move_y   = (e2 <= dx_cmp);
    err_step = err_r + (move_x ? ndy_w : '0) + (move_y ? dx_w : '0);
    x_step   = cur_x_r;
    y_step   = cur_y_r;
    if (move_x) begin
      x_step = sx_neg_r ? cur_x_r - ONE_C : cur_x_r + ONE_C;
    end
    if (move_y) begin
      y_step = sy_neg_r ? cur_y_r - ONE_C : cur_y_r + ONE_C;
    end
  end

  // Select start setup or step, then classify the pixel
  always_comb begin
    e_ndy_w    = EW'(e_ndy);
    e_dx_w     = $signed(EW'(e_dx));
    is_start   = (e_mode == MODE_START);
    do_emit    = is_start || active_r;
    fire       = q_status.has_data && (!out_valid_r || out_ready);
    cur_x_nxt  = is_start ? e_x0 : x_step;
    cur_y_nxt  = is_start ? e_y0 : y_step;
    goal_x_nxt = is_start ? e_x1 : goal_x_r;
    goal_y_nxt = is_start ? e_y1 : goal_y_r;
    err_nxt    = is_start ? (e_dx_w + e_ndy_w) : err_step;
    at_end     = (cur_x_nxt == goal_x_nxt) && (cur_y_nxt == goal_y_nxt);
    px_c       = CMPW'(cur_x_nxt);
    py_c       = CMPW'(cur_y_nxt);
    w_c        = $signed(CMPW'(canvas_w_r));
    h_c        = $signed(CMPW'(canvas_h_r));
    inside_nxt = (px_c >= 0) && (px_c < w_c) && (py_c >= 0) && (py_c < h_c);
  end

  assign q_pop = fire;

  // Hold control state: line activity, result valid, canvas registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      canvas_w_r  <= CANVAS_WIDTH_RESET;
      canvas_h_r  <= CANVAS_HEIGHT_RESET;
    end else begin
      if (fire && do_emit) begin
        active_r    <= !at_end;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CANVAS_WIDTH:  canvas_w_r <= cfg_wdata;
          CFG_CANVAS_HEIGHT: canvas_h_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Update line state and load the result register
  always_ff @(posedge clk) begin
    if (fire && do_emit) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      goal_x_r <= goal_x_nxt;
      goal_y_r <= goal_y_nxt;
      err_r    <= err_nxt;
      pix_x_r  <= cur_x_nxt;
      pix_y_r  <= cur_y_nxt;
      inside_r <= inside_nxt;
      last_r   <= at_end;
      if (is_start) begin
        dx_r     <= e_dx;
        ndy_r    <= e_ndy;
        sx_neg_r <= e_sx;
        sy_neg_r <= e_sy;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_x    = pix_x_r;
  assign pixel_y    = pix_y_r;
  assign inside_res = inside_r;
  assign last       = last_r;

endmodule
`default_nettype wire

// File: rtl/bresenham_line_stepper_unit.sv
`default_nettype none
// Bresenham line stepper, all octants, one pixel per request. A start request
// (in_tuser = 0) loads both endpoints and returns the first pixel; a step
// request (in_tuser = 1) returns the next pixel, or nothing when no line is
// active. Each result carries the pixel on out_tdata, an inside-canvas flag on
// out_tuser and the endpoint flag on out_tlast. The block sustains one request
// per clock while the output is not stalled: the step update in the back end is
// combinational, and a short request queue separates input acceptance from the
// result register. A request's pixel reaches the output through the queue slot
// and then the result register. Canvas width and height are written through the
// cfg port by the user while the block is idle; the block does not enforce it.
module bresenham_line_stepper_unit #(
  parameter int COORD_BITS  = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          cfg_we,
  input  wire logic [bls_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
  input  wire logic [bls_pkg::CANVAS_BITS-1:0]               cfg_wdata,
  input  wire logic                                          in_tvalid,
  output logic                                               in_tready,
  // in_tdata, lowest bit up: x_start, y_start, x_end, y_end, zero fill
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]             in_tdata,
  // in_tuser: mode
  input  wire logic                                          in_tuser,
  output logic                                               out_tvalid,
  input  wire logic                                          out_tready,
  // out_tdata, lowest bit up: pixel_x, pixel_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]                  out_tdata,
  // out_tuser: inside_res
  output logic                                               out_tuser,
  output logic                                               out_tlast
);
  import bls_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int QW    = 6*CB + 6;
  localparam int OUT_W = ((2*CB+7)/8)*8;

  logic [QW-1:0]        f_entry;
  logic [QW-1:0]        q_entry;
  bls_q_status_t        q_status;
  logic                 q_push;
  logic                 q_pop;
  logic signed [CB-1:0] pixel_x;
  logic signed [CB-1:0] pixel_y;

  assign in_tready = q_status.can_push;
  assign q_push    = in_tvalid && in_tready;

  // Classify requests and set up line parameters
  bls_front #(
    .COORD_BITS(CB)
  ) u_front (
    .in_mode (in_tuser),
    .x_start (in_tdata[0*CB +: CB]),
    .y_start (in_tdata[1*CB +: CB]),
    .x_end   (in_tdata[2*CB +: CB]),
    .y_end   (in_tdata[3*CB +: CB]),
    .entry   (f_entry)
  );

  // Buffer requests between front and back
  bls_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (f_entry),
    .pop       (q_pop),
    .pop_data  (q_entry),
    .status    (q_status)
  );

  // Step the line and register results
  bls_back #(
    .COORD_BITS(CB)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_status   (q_status),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .inside_res (out_tuser),
    .last       (out_tlast)
  );

  assign out_tdata = OUT_W'({pixel_y, pixel_x});

endmodule
`default_nettype wire
